// File: rtl/core/fvcw_pkg.sv
// shared types, constants and colour wheel table for the flow colour block
// no dependencies
package fvcw_pkg;

    localparam int HueFracBits = 8;
    localparam int AngleBits   = 20;
    localparam int CordicSteps = 16;
    localparam int WheelSize   = 55;
    localparam int CordicW     = 27;
    localparam int ZW          = 22;
    localparam int FlowW       = 16;
    localparam int MagW        = 16;

    localparam logic [7:0] YgDn [6]  = '{8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43};
    localparam logic [7:0] GcUp [4]  = '{8'd0, 8'd63, 8'd127, 8'd191};
    localparam logic [7:0] CbDn [11] = '{8'd255, 8'd232, 8'd209, 8'd186, 8'd163, 8'd140,
                                        8'd116, 8'd93, 8'd70, 8'd47, 8'd24};
    localparam logic [7:0] BmUp [13] = '{8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117,
                                        8'd137, 8'd156, 8'd176, 8'd196, 8'd215, 8'd235};

    localparam logic [1:0] ChRed   = 2'd0;
    localparam logic [1:0] ChGreen = 2'd1;
    localparam logic [1:0] ChBlue  = 2'd2;

    typedef struct packed {
        logic       ld;
        logic       sqa;
        logic       sqb;
        logic       iter;
        logic       hue;
        logic       chw;
        logic       mul;
        logic       div;
        logic       sto;
        logic       fin;
        logic [3:0] cnt;
        logic [1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic colour;
    } t_sts;

    function automatic logic [17:0] atan_tab(input logic [3:0] i);
        logic [17:0] v;
        unique case (i)
            4'd0:    v = 18'd131072;
            4'd1:    v = 18'd77376;
            4'd2:    v = 18'd40884;
            4'd3:    v = 18'd20753;
            4'd4:    v = 18'd10417;
            4'd5:    v = 18'd5213;
            4'd6:    v = 18'd2607;
            4'd7:    v = 18'd1304;
            4'd8:    v = 18'd652;
            4'd9:    v = 18'd326;
            4'd10:   v = 18'd163;
            4'd11:   v = 18'd81;
            4'd12:   v = 18'd41;
            4'd13:   v = 18'd20;
            4'd14:   v = 18'd10;
            default: v = 18'd5;
        endcase
        return v;
    endfunction

    // wheel entry k, channel ch
    function automatic logic [7:0] wheel(input logic [5:0] k, input logic [1:0] ch);
        logic [7:0] r, g, b, v;
        logic [5:0] o;
        r = 8'd0; g = 8'd0; b = 8'd0; o = 6'd0;
        priority if (k < 6'd15) begin
            r = 8'd255; g = 8'(k * 6'd17);
        end else if (k < 6'd21) begin
            o = k - 6'd15; r = YgDn[o[2:0]]; g = 8'd255;
        end else if (k < 6'd25) begin
            o = k - 6'd21; g = 8'd255; b = GcUp[o[1:0]];
        end else if (k < 6'd36) begin
            o = k - 6'd25; g = CbDn[o[3:0]]; b = 8'd255;
        end else if (k < 6'd49) begin
            o = k - 6'd36; r = BmUp[o[3:0]]; b = 8'd255;
        end else if (k < 6'd55) begin
            o = k - 6'd49; r = 8'd255; b = YgDn[o[2:0]];
        end
        unique case (ch)
            ChRed:   v = r;
            ChGreen: v = g;
            default: v = b;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/fvcw_ctrl.sv
// sequencing state machine for the flow colour block
// depends on fvcw_pkg for the command and status structs
module fvcw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  fvcw_pkg::t_sts  i_sts,
    output fvcw_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQA  = 4'd1;
    localparam logic [3:0] S_SQB  = 4'd2;
    localparam logic [3:0] S_ITER = 4'd3;
    localparam logic [3:0] S_HUE  = 4'd4;
    localparam logic [3:0] S_CHW  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_STO  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_ch, n_ch;
    logic       r_ovalid, n_ovalid;
    logic       fin;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign fin        = (r_state == S_DONE) && (!r_ovalid || i_m_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ch    = r_ch;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_SQA;
            S_SQA:  n_state = S_SQB;
            S_SQB: begin
                n_state = S_ITER; n_cnt = 4'd0;
            end
            S_ITER: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = i_sts.colour ? S_HUE : S_DONE;
                end
            end
            S_HUE: begin
                n_state = S_CHW; n_ch = fvcw_pkg::ChRed;
            end
            S_CHW:  n_state = S_MUL;
            S_MUL: begin
                n_state = S_DIV; n_cnt = 4'd7;
            end
            S_DIV: begin
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) n_state = S_STO;
            end
            S_STO: begin
                n_ch = r_ch + 2'd1;
                n_state = (r_ch == fvcw_pkg::ChBlue) ? S_DONE : S_CHW;
            end
            S_DONE: if (fin) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_m_tready) n_ovalid = 1'b0;
        if (fin && i_sts.colour)    n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd0;
            r_ch     <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.ld   = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.sqa  = (r_state == S_SQA);
        o_cmd.sqb  = (r_state == S_SQB);
        o_cmd.iter = (r_state == S_ITER);
        o_cmd.hue  = (r_state == S_HUE);
        o_cmd.chw  = (r_state == S_CHW);
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.div  = (r_state == S_DIV);
        o_cmd.sto  = (r_state == S_STO);
        o_cmd.fin  = fin;
        o_cmd.cnt  = r_cnt;
        o_cmd.ch   = r_ch;
    end

endmodule

// File: rtl/core/fvcw_dp.sv
// datapath: squares, bit-serial square root, cordic angle, hue blend and divider
// depends on fvcw_pkg for constants, wheel table and command structs
module fvcw_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_s_tdata,
    input  logic [2:0]      i_s_tuser,
    output logic [23:0]     o_m_tdata,
    input  fvcw_pkg::t_cmd  i_cmd,
    output fvcw_pkg::t_sts  o_sts
);

    localparam int CW = fvcw_pkg::CordicW;
    localparam int ZW = fvcw_pkg::ZW;

    logic signed [15:0] r_x, r_y;
    logic               r_func, r_unk, r_fs;
    logic [31:0]        r_px, r_sq;
    logic [15:0]        r_root, r_max;
    logic [16:0]        r_rem;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_z;
    logic [1:0]         r_quad;
    logic               r_axis, r_zero;
    logic [5:0]         r_k0;
    logic [7:0]         r_fr;
    logic               r_within;
    logic [15:0]        r_hv;
    logic [32:0]        r_drem;
    logic [7:0]         r_q;
    logic [7:0]         r_chv [3];
    logic [23:0]        r_out;

    // quadrant fold of the incoming vector
    logic signed [15:0] ix, iy;
    logic signed [16:0] fx, fy, ex, ey;
    logic [1:0]         fq;
    assign ix = i_s_tdata[15:0];
    assign iy = i_s_tdata[31:16];
    assign ex = 17'(ix);
    assign ey = 17'(iy);
    always_comb begin
        priority if (ix > 16'sd0 && iy >= 16'sd0) begin
            fq = 2'd0; fx = ex;  fy = ey;
        end else if (ix <= 16'sd0 && iy > 16'sd0) begin
            fq = 2'd1; fx = ey;  fy = -ex;
        end else if (ix < 16'sd0 && iy <= 16'sd0) begin
            fq = 2'd2; fx = -ex; fy = -ey;
        end else begin
            fq = 2'd3; fx = -ey; fy = ex;
        end
    end

    // one root bit per step
    logic [18:0] sr_rem2, sr_t;
    assign sr_rem2 = {r_rem, r_sq[31:30]};
    assign sr_t    = {1'b0, r_root, 2'b01};

    // one cordic rotation per step
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] at;
    assign sh_x = r_cx >>> i_cmd.cnt;
    assign sh_y = r_cy >>> i_cmd.cnt;
    assign at   = ZW'(fvcw_pkg::atan_tab(i_cmd.cnt));

    // angle and hue index
    logic [17:0] zc;
    logic [19:0] ang;
    logic [25:0] fkp;
    logic [5:0]  k0;
    always_comb begin
        if (r_z < 0) zc = 18'd0;
        else if (r_z > ZW'(18'h3FFFF)) zc = 18'h3FFFF;
        else zc = r_z[17:0];
        if (r_zero) ang = 20'd0;
        else if (r_axis) ang = {r_quad, 18'd0};
        else ang = {r_quad, zc};
        fkp = 26'(ang) * 26'd54;
        k0  = fkp[25:20];
        if (k0 > 6'd53) k0 = 6'd53;
    end

    logic [8:0]  wa;
    logic [16:0] hsum;
    assign wa   = 9'd256 - 9'(r_fr);
    assign hsum = 17'(wa * fvcw_pkg::wheel(r_k0, i_cmd.ch))
                + 17'(r_fr * fvcw_pkg::wheel(r_k0 + 6'd1, i_cmd.ch));

    logic [23:0] den;
    logic [32:0] dsh;
    logic [17:0] dim;
    assign den = {r_max, 8'd0};
    assign dsh = {9'd0, den} << i_cmd.cnt[2:0];
    assign dim = 18'(r_hv) * 18'd3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_x <= ix; r_y <= iy;
            r_func <= i_s_tuser[0]; r_unk <= i_s_tuser[1]; r_fs <= i_s_tuser[2];
            r_quad <= fq;
            r_axis <= (fy == 17'sd0);
            r_zero <= (ix == 16'sd0) && (iy == 16'sd0);
            r_cx <= CW'({fx, 8'd0});
            r_cy <= CW'({fy, 8'd0});
            r_z  <= '0;
        end
        if (i_cmd.sqa) r_px <= 32'(r_x * r_x);
        if (i_cmd.sqb) begin
            r_sq   <= r_px + 32'(r_y * r_y);
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.iter) begin
            r_sq <= {r_sq[29:0], 2'b00};
            if (sr_rem2 >= sr_t) begin
                r_rem  <= 17'(sr_rem2 - sr_t);
                r_root <= {r_root[14:0], 1'b1};
            end else begin
                r_rem  <= sr_rem2[16:0];
                r_root <= {r_root[14:0], 1'b0};
            end
            if (r_cy > 0) begin
                r_cx <= r_cx + sh_y; r_cy <= r_cy - sh_x; r_z <= r_z + at;
            end else begin
                r_cx <= r_cx - sh_y; r_cy <= r_cy + sh_x; r_z <= r_z - at;
            end
        end
        if (i_cmd.hue) begin
            r_k0 <= k0;
            r_fr <= fkp[19:12];
            r_within <= (r_root <= r_max);
        end
        if (i_cmd.chw) r_hv <= hsum[15:0];
        if (i_cmd.mul) begin
            r_drem <= 33'(r_root * (16'd65280 - r_hv)) + 33'(den) - 33'd1;
            r_q    <= '0;
        end
        if (i_cmd.div && r_drem >= dsh) begin
            r_drem <= r_drem - dsh;
            r_q[i_cmd.cnt[2:0]] <= 1'b1;
        end
        if (i_cmd.sto) r_chv[i_cmd.ch] <= r_within ? 8'd255 - r_q : dim[17:10];
        if (i_cmd.fin && r_func) begin
            if (r_unk) r_out <= 24'd0;
            else if (r_max == 16'd0) r_out <= 24'hFFFFFF;
            else r_out <= {r_chv[2], r_chv[1], r_chv[0]};
        end
    end

    // running maximum, restarted from the measure's magnitude (zero if unknown) on a frame-start measure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cmd.fin && !r_func) begin
            if (r_fs) r_max <= r_unk ? 16'd0 : r_root;
            else if (!r_unk && r_root > r_max) r_max <= r_root;
        end
    end

    assign o_sts.colour = r_func;
    assign o_m_tdata    = r_out;

endmodule

// File: rtl/core/flow_vector_to_colour_wheel.sv
// a colour result follows the input transaction after the 16-step root/cordic loop
// and three channel passes through the shared serial divider
// the block takes no new item until the last one is done; measure items give no result
// the result register lets the next item start while a result waits
// reset (synchronous, active low) clears the frame maximum and the control state
module flow_vector_to_colour_wheel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // flow_x, flow_y
    input  logic [2:0]  i_s_tuser,  // func, flow_unknown, frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // red, green, blue
);

    fvcw_pkg::t_cmd cmd;
    fvcw_pkg::t_sts sts;

    fvcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fvcw_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

endmodule

// File: rtl/core/fvcw_chk.sv
// port-level checks for the flow colour block, bound to the top level
// depends on flow_vector_to_colour_wheel ports only
module fvcw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // a result only appears at the end of work
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without work");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind flow_vector_to_colour_wheel fvcw_chk u_fvcw_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
